### src/display_text_sanitizer_top_macros.svh
// assertion macros shared by the display text sanitizer rtl
`ifndef DISPLAY_TEXT_SANITIZER_TOP_MACROS_SVH
`define DISPLAY_TEXT_SANITIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define DTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("display text sanitizer assertion failed");

// property checked on every clock edge, reset included
`define DTS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("display text sanitizer assertion failed");

`else

`define DTS_ASSERT(lbl, clk, rstn, prop)
`define DTS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### src/dts_pkg.sv
// types and byte codes of the display text sanitizer
`default_nettype none

package dts_pkg;

  // bytes of lookahead the judge unit looks at
  localparam int unsigned PEEK_N = 8;
  localparam int unsigned MAX_CHARS = 3;

  localparam logic [7:0] BYTE_NUL   = 8'd0;
  localparam logic [7:0] BYTE_NL    = 8'd10;
  localparam logic [7:0] BYTE_SPACE = 8'd32;
  localparam logic [7:0] LEAD_2B    = 8'd195;
  localparam logic [7:0] LEAD_3B    = 8'd226;
  localparam logic [7:0] CONT_128   = 8'd128;
  localparam logic [7:0] CONT_ELLIP = 8'd166;
  localparam logic [7:0] CONT_A     = 8'd160;
  localparam logic [7:0] CONT_E     = 8'd168;
  localparam logic [7:0] CONT_I     = 8'd172;
  localparam logic [7:0] CONT_O     = 8'd178;
  localparam logic [7:0] CONT_U     = 8'd185;

  localparam logic [7:0] CH8_H     = 8'h68;
  localparam logic [7:0] CH8_T     = 8'h74;
  localparam logic [7:0] CH8_P     = 8'h70;
  localparam logic [7:0] CH8_S     = 8'h73;
  localparam logic [7:0] CH8_COLON = 8'h3a;
  localparam logic [7:0] CH8_SLASH = 8'h2f;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_STAR  = 7'h2a;
  localparam logic [6:0] CH_APOS  = 7'h27;
  localparam logic [6:0] CH_DOT   = 7'h2e;
  localparam logic [6:0] CH_A     = 7'h61;
  localparam logic [6:0] CH_E     = 7'h65;
  localparam logic [6:0] CH_I     = 7'h69;
  localparam logic [6:0] CH_O     = 7'h6f;
  localparam logic [6:0] CH_U     = 7'h75;

  // what judging the oldest byte does
  typedef struct packed {
    logic [1:0]                    cnt;
    logic [MAX_CHARS-1:0][6:0]     chars;
    logic [1:0]                    skip_d;
    logic                          link_d;
  } act_t;

  // window control from the sequencer
  typedef struct packed {
    logic push;
    logic shift;
  } win_ctrl_t;

endpackage

`default_nettype wire

### src/display_text_sanitizer_top.sv
// display text sanitizer: byte window, judge unit and output sequencer
//
// Input channel in_valid_i/in_ready_o carries one text byte per word with
// in_last_i marking the final byte. Output channel out_valid_o/out_ready_i
// carries one result word: a 7-bit character, or a bare end marker with
// end_of_text_o set after the last character of a text.
// Bytes fill a LOOKAHEAD_DEPTH byte window. While the window is not yet
// full, bytes are taken back to back with no judge step. Once it fills,
// each byte is accepted, judged in the shared compare unit, and then its
// characters (0 to 3) are emitted one by one before the next byte is taken.
// The last byte flushes the window: each held byte is judged and its
// characters are emitted, then the end marker goes out.
// in_ready_o is low while a byte is judged, its characters are emitted or the end marker waits.
// A stalled receiver holds the output register and the sequencer waits;
// no word is dropped.
// Reset clears the window, fill count and link/skip state; the block is
// ready straight out of reset.
`default_nettype none
`include "display_text_sanitizer_top_macros.svh"

module display_text_sanitizer_top import dts_pkg::*; #(
  parameter int unsigned LOOKAHEAD_DEPTH = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [6:0] out_char_o,
  output logic            char_valid_o,
  output logic            end_of_text_o
);

  localparam int unsigned FILL_W = $clog2(LOOKAHEAD_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_JUDGE,
    S_EMIT,
    S_END
  } state_e;

  state_e                      state_q;
  logic                        flush_q;
  logic [1:0]                  skip_q;
  logic                        link_q;
  logic [1:0]                  cnt_q;
  logic [1:0]                  idx_q;
  logic [MAX_CHARS-1:0][6:0]   chars_q;
  logic                        out_valid_q;
  logic [6:0]                  out_char_q;
  logic                        char_valid_q;
  logic                        eot_q;

  win_ctrl_t                   win_ctrl;
  logic [FILL_W-1:0]           fill;
  logic [FILL_W-1:0]           fill_dec;
  logic [PEEK_N-1:0][7:0]      peek;
  act_t                        act;
  logic                        in_acc;
  logic                        slot_free;
  logic                        full_next;
  logic                        out_load;

  dts_window #(
    .DEPTH (LOOKAHEAD_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .byte_i (in_byte_i),
    .fill_o (fill),
    .peek_o (peek)
  );

  dts_judge u_judge (
    .peek_i (peek),
    .skip_i (skip_q),
    .link_i (link_q),
    .act_o  (act)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign full_next  = (fill == FILL_W'(LOOKAHEAD_DEPTH - 1));
  assign fill_dec   = FILL_W'(fill - 1'b1);
  // output register takes a new word this cycle
  assign out_load   = slot_free && (state_q == S_EMIT || state_q == S_END);

  always_comb begin
    win_ctrl.push  = in_acc;
    win_ctrl.shift = (state_q == S_JUDGE);
  end

  // where to go once a judged byte has no characters left to emit
  function automatic state_e after_byte(input logic flush, input logic [FILL_W-1:0] f);
    state_e s;
    if (!flush) s = S_IDLE;
    else if (f == '0) s = S_END;
    else s = S_JUDGE;
    return s;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      flush_q      <= 1'b0;
      skip_q       <= 2'd0;
      link_q       <= 1'b0;
      cnt_q        <= 2'd0;
      idx_q        <= 2'd0;
      out_valid_q  <= 1'b0;
      chars_q      <= '0;
      out_char_q   <= 7'd0;
      char_valid_q <= 1'b0;
      eot_q        <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            flush_q <= in_last_i;
            if (in_last_i || full_next) state_q <= S_JUDGE;
          end
        end
        S_JUDGE: begin
          skip_q  <= act.skip_d;
          link_q  <= act.link_d;
          chars_q <= act.chars;
          cnt_q   <= act.cnt;
          idx_q   <= 2'd0;
          if (act.cnt != 2'd0) state_q <= S_EMIT;
          else state_q <= after_byte(flush_q, fill_dec);
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            out_char_q   <= chars_q[idx_q];
            char_valid_q <= 1'b1;
            eot_q        <= 1'b0;
            idx_q        <= 2'(idx_q + 2'd1);
            if (idx_q == 2'(cnt_q - 2'd1)) state_q <= after_byte(flush_q, fill);
          end
        end
        S_END: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            out_char_q   <= 7'd0;
            char_valid_q <= 1'b0;
            eot_q        <= 1'b1;
            flush_q      <= 1'b0;
            skip_q       <= 2'd0;
            link_q       <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign char_valid_o  = char_valid_q;
  assign end_of_text_o = eot_q;

  // a byte is only taken while the window has room for it
  `DTS_ASSERT(a_no_overflow, clk_i, rst_ni, in_ready_o |-> (fill < FILL_W'(LOOKAHEAD_DEPTH)))
  // the end marker never carries a character
  `DTS_ASSERT(a_marker_bare, clk_i, rst_ni, (out_valid_o && end_of_text_o) |-> !char_valid_o)
  // once the end marker goes out the window is empty and input reopens
  `DTS_ASSERT(a_end_empties, clk_i, rst_ni,
    (state_q == S_END && slot_free) |=> (fill == '0 && in_ready_o && !link_q))
  // a multibyte skip never exceeds two bytes
  `DTS_ASSERT_ALWAYS(a_skip_range, clk_i, skip_q != 2'd3)

endmodule

`default_nettype wire

### src/dts_window.sv
// lookahead window: shift register of text bytes with fill count
`default_nettype none

module dts_window import dts_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire win_ctrl_t                      ctrl_i,
  input  wire logic [7:0]                     byte_i,
  output logic      [$clog2(DEPTH+1)-1:0]     fill_o,
  output logic      [PEEK_N-1:0][7:0]         peek_o
);

  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(DEPTH);

  logic [7:0]        win_q [DEPTH];
  logic [FILL_W-1:0] fill_q;

  // entries at or above the fill count always hold zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) win_q[k] <= 8'd0;
      fill_q <= '0;
    end else if (ctrl_i.shift) begin
      for (int k = 0; k < DEPTH - 1; k++) win_q[k] <= win_q[k+1];
      win_q[DEPTH-1] <= 8'd0;
      fill_q <= FILL_W'(fill_q - 1'b1);
    end else if (ctrl_i.push) begin
      win_q[fill_q[IDX_W-1:0]] <= byte_i;
      fill_q <= FILL_W'(fill_q + 1'b1);
    end
  end

  assign fill_o = fill_q;

  for (genvar g = 0; g < PEEK_N; g++) begin : g_peek
    assign peek_o[g] = win_q[g];
  end

endmodule

`default_nettype wire

### src/dts_judge.sv
// compare unit that judges the oldest window byte against its lookahead
`default_nettype none

module dts_judge import dts_pkg::*; (
  input  wire logic [PEEK_N-1:0][7:0] peek_i,
  input  wire logic [1:0]             skip_i,
  input  wire logic                   link_i,
  output act_t                        act_o
);

  logic [7:0] b;
  logic       link_start;
  logic [6:0] vowel;

  assign b = peek_i[0];

  always_comb begin
    link_start = 1'b0;
    if (peek_i[0] == CH8_H && peek_i[1] == CH8_T && peek_i[2] == CH8_T &&
        peek_i[3] == CH8_P) begin
      if (peek_i[4] == CH8_COLON && peek_i[5] == CH8_SLASH && peek_i[6] == CH8_SLASH)
        link_start = 1'b1;
      else if (peek_i[4] == CH8_S && peek_i[5] == CH8_COLON &&
               peek_i[6] == CH8_SLASH && peek_i[7] == CH8_SLASH)
        link_start = 1'b1;
    end
  end

  always_comb begin
    case (peek_i[1])
      CONT_A:  vowel = CH_A;
      CONT_E:  vowel = CH_E;
      CONT_I:  vowel = CH_I;
      CONT_O:  vowel = CH_O;
      CONT_U:  vowel = CH_U;
      default: vowel = 7'd0;
    endcase
  end

  always_comb begin
    act_o        = '0;
    act_o.skip_d = skip_i;
    act_o.link_d = link_i;
    if (skip_i != 2'd0) begin
      act_o.skip_d = 2'(skip_i - 2'd1);
    end else if (link_i) begin
      if (b == BYTE_SPACE || b == BYTE_NUL) act_o.link_d = 1'b0;
    end else if (b == BYTE_NL) begin
      act_o.cnt      = 2'd1;
      act_o.chars[0] = CH_SPACE;
    end else if (b[7]) begin
      if (b == LEAD_2B) begin
        // two-byte accented vowel, unknown second byte drops both
        if (vowel != 7'd0) begin
          act_o.cnt      = 2'd2;
          act_o.chars[0] = vowel;
          act_o.chars[1] = CH_APOS;
        end
        act_o.skip_d = 2'd1;
      end else if (b == LEAD_3B) begin
        if (peek_i[1] == CONT_128 && peek_i[2] == CONT_ELLIP) begin
          act_o.cnt      = 2'd3;
          act_o.chars[0] = CH_DOT;
          act_o.chars[1] = CH_DOT;
          act_o.chars[2] = CH_DOT;
          act_o.skip_d   = 2'd2;
        end
      end else begin
        act_o.cnt      = 2'd1;
        act_o.chars[0] = CH_STAR;
      end
    end else if (link_start) begin
      act_o.link_d = 1'b1;
    end else if (b != BYTE_NUL) begin
      act_o.cnt      = 2'd1;
      act_o.chars[0] = b[6:0];
    end
  end

endmodule

`default_nettype wire
